@@ rtl/cap_pkg.sv @@
`default_nettype none
package cap_pkg;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_SUB   = 2'd1,
    CMD_MUL   = 2'd2,
    CMD_POLAR = 2'd3
  } cmd_t;

  localparam int XW = 31;
  localparam int RW = 34;

  localparam logic signed [RW-1:0] Q24_PI            = 34'sd52707179;
  localparam logic signed [RW-1:0] Q24_HALF_PI       = 34'sd26353589;
  localparam logic signed [RW-1:0] Q24_THREE_HALF_PI = 34'sd79060768;
  localparam logic [29:0]          INV_GAIN_Q30      = 30'd652032874;

  function automatic logic signed [RW-1:0] atan_q24(input logic [4:0] idx);
    logic signed [RW-1:0] v;
    case (idx)
      5'd0:    v = 34'sd13176795;
      5'd1:    v = 34'sd7778716;
      5'd2:    v = 34'sd4110060;
      5'd3:    v = 34'sd2086331;
      5'd4:    v = 34'sd1047214;
      5'd5:    v = 34'sd524117;
      5'd6:    v = 34'sd262123;
      5'd7:    v = 34'sd131069;
      5'd8:    v = 34'sd65536;
      5'd9:    v = 34'sd32768;
      5'd10:   v = 34'sd16384;
      5'd11:   v = 34'sd8192;
      5'd12:   v = 34'sd4096;
      5'd13:   v = 34'sd2048;
      5'd14:   v = 34'sd1024;
      5'd15:   v = 34'sd512;
      5'd16:   v = 34'sd256;
      5'd17:   v = 34'sd128;
      5'd18:   v = 34'sd64;
      5'd19:   v = 34'sd32;
      5'd20:   v = 34'sd16;
      5'd21:   v = 34'sd8;
      5'd22:   v = 34'sd4;
      5'd23:   v = 34'sd2;
      5'd24:   v = 34'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ rtl/complex_alu_polar.sv @@
`default_nettype none
// Channel | Direction | Ports
// in_     | input     | in_valid, in_ready, in_cmd, in_a_re, in_a_im, in_b_re, in_b_im
// out_    | output    | out_valid, out_ready, out_res_re, out_res_im
//
// One item per cycle while the output is not stalled. The input register loads
// at the transfer, then one register stage per CORDIC iteration, then the
// gain-multiply and output registers, after which the result is valid.
// Reset clears all valid bits. A stalled output holds the whole pipeline.
module complex_alu_polar #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [1:0]                in_cmd,
  input  wire logic signed [15:0]        in_a_re,
  input  wire logic signed [15:0]        in_a_im,
  input  wire logic signed [15:0]        in_b_re,
  input  wire logic signed [15:0]        in_b_im,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [cap_pkg::RW-1:0]  out_res_re,
  output logic signed [cap_pkg::RW-1:0]  out_res_im
);

  localparam int N  = CORDIC_STAGES;
  localparam int XW = cap_pkg::XW;
  localparam int RW = cap_pkg::RW;

  logic adv;

  logic                 v_r   [0:N];
  logic                 byp_r [0:N];
  logic signed [RW-1:0] rr_r  [0:N];
  logic signed [RW-1:0] ri_r  [0:N];
  logic signed [XW-1:0] x_r   [0:N];
  logic signed [XW-1:0] y_r   [0:N];
  logic signed [RW-1:0] z_r   [0:N];

  logic                 mv_r, mbyp_r;
  logic signed [RW-1:0] mrr_r, mri_r, mz_r;
  logic [60:0]          prod_r;

  logic                 ov_r;
  logic signed [RW-1:0] ore_r, oim_r;

  logic                 byp_nxt;
  logic signed [RW-1:0] rr_nxt, ri_nxt, z_nxt;
  logic signed [XW-1:0] x_nxt, y_nxt;
  logic signed [16:0]   are, aim, sum_re, sum_im, abs_im;
  logic signed [32:0]   mre, mim;
  logic [60:0]          rnd;

  assign adv      = !ov_r || out_ready;
  assign in_ready = adv;

  always_comb begin
    are    = 17'(in_a_re);
    aim    = 17'(in_a_im);
    abs_im = aim[16] ? -aim : aim;
    mre    = 33'(32'(in_a_re * in_b_re)) - 33'(32'(in_a_im * in_b_im));
    mim    = 33'(32'(in_a_re * in_b_im)) + 33'(32'(in_a_im * in_b_re));
    sum_re = 17'(in_a_re) + 17'(in_b_re);
    sum_im = 17'(in_a_im) + 17'(in_b_im);
    byp_nxt = 1'b1;
    rr_nxt  = '0;
    ri_nxt  = '0;
    x_nxt   = '0;
    y_nxt   = '0;
    z_nxt   = '0;
    case (cap_pkg::cmd_t'(in_cmd))
      cap_pkg::CMD_ADD: begin
        rr_nxt = RW'(signed'({sum_re, 12'd0}));
        ri_nxt = RW'(signed'({sum_im, 12'd0}));
      end
      cap_pkg::CMD_SUB: begin
        sum_re = 17'(in_a_re) - 17'(in_b_re);
        sum_im = 17'(in_a_im) - 17'(in_b_im);
        rr_nxt = RW'(signed'({sum_re, 12'd0}));
        ri_nxt = RW'(signed'({sum_im, 12'd0}));
      end
      cap_pkg::CMD_MUL: begin
        rr_nxt = RW'(mre);
        ri_nxt = RW'(mim);
      end
      default: begin
        if (are == '0) begin
          rr_nxt = RW'(signed'({abs_im, 12'd0}));
          if (aim > 0)      ri_nxt = cap_pkg::Q24_HALF_PI;
          else if (aim < 0) ri_nxt = cap_pkg::Q24_THREE_HALF_PI;
          else              ri_nxt = '0;
        end else begin
          byp_nxt = 1'b0;
          if (are[16]) begin
            x_nxt = XW'(signed'({-are, 12'd0}));
            y_nxt = XW'(signed'({-aim, 12'd0}));
            z_nxt = cap_pkg::Q24_PI;
          end else begin
            x_nxt = XW'(signed'({are, 12'd0}));
            y_nxt = XW'(signed'({aim, 12'd0}));
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (adv) begin
      v_r[0] <= in_valid;
    end
    if (adv) begin
      byp_r[0] <= byp_nxt;
      rr_r[0]  <= rr_nxt;
      ri_r[0]  <= ri_nxt;
      x_r[0]   <= x_nxt;
      y_r[0]   <= y_nxt;
      z_r[0]   <= z_nxt;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    logic signed [XW-1:0] xs, ys;
    logic signed [RW-1:0] at;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    assign at = cap_pkg::atan_q24(5'(i));
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (adv) begin
        v_r[i+1] <= v_r[i];
      end
      if (adv) begin
        byp_r[i+1] <= byp_r[i];
        rr_r[i+1]  <= rr_r[i];
        ri_r[i+1]  <= ri_r[i];
        if (!y_r[i][XW-1]) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + at;
        end else begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - at;
        end
      end
    end
  end

  assign rnd = prod_r + (61'd1 << 29);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
      ov_r <= 1'b0;
    end else if (adv) begin
      mv_r <= v_r[N];
      ov_r <= mv_r;
    end
    if (adv) begin
      mbyp_r <= byp_r[N];
      mrr_r  <= rr_r[N];
      mri_r  <= ri_r[N];
      mz_r   <= z_r[N];
      prod_r <= 61'(x_r[N]) * 61'(cap_pkg::INV_GAIN_Q30);
      ore_r  <= mbyp_r ? mrr_r : RW'(rnd[60:30]);
      oim_r  <= mbyp_r ? mri_r : mz_r;
    end
  end

  assign out_valid  = ov_r;
  assign out_res_re = ore_r;
  assign out_res_im = oim_r;

endmodule
`default_nettype wire
